[src/lrp_pkg.sv]
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared types and constants of the LRU residency table with pinning.
// ----------------------------------------------------------------------------
package lrp_pkg;

  localparam int OP_W         = 3;
  localparam int KEY_W        = 16;
  localparam int STATUS_W     = 2;
  localparam int MAXR_W       = 5;
  localparam int MAX_RESULTS  = 16;
  localparam int NRES_W       = $clog2(MAX_RESULTS + 1);
  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 16;

  localparam logic [MAXR_W-1:0] MAXR_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_TOUCH  = 3'd0,
    OP_PIN    = 3'd1,
    OP_UNPIN  = 3'd2,
    OP_FORGET = 3'd3,
    OP_EVALL  = 3'd4,
    OP_TRIM   = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_LIMIT = 2'd0,
    MODE_ALL   = 2'd1,
    MODE_ROOM  = 2'd2
  } ev_mode_e;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_FIND   = 9'b000000010,
    S_DECIDE = 9'b000000100,
    S_SCAN   = 9'b000001000,
    S_RDKEY  = 9'b000010000,
    S_EMIT   = 9'b000100000,
    S_INSERT = 9'b001000000,
    S_CHECK  = 9'b010000000,
    S_FLUSH  = 9'b100000000
  } state_e;

endpackage

[src/lrp_in_if.sv]
// ----------------------------------------------------------------------------
// lrp_in_if
// Request channel: operation and key, valid/ready.
// ----------------------------------------------------------------------------
interface lrp_in_if import lrp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [KEY_W-1:0]  key;

  modport source (output valid, operation, key, input ready);
  modport sink   (input valid, operation, key, output ready);
endinterface

[src/lrp_out_if.sv]
// ----------------------------------------------------------------------------
// lrp_out_if
// Result channel: one beat per eviction or one empty beat, valid/ready.
// ----------------------------------------------------------------------------
interface lrp_out_if import lrp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                hit;
  logic [STATUS_W-1:0] status;
  logic                evicted_valid;
  logic [KEY_W-1:0]    evicted_key;
  logic                last;

  modport source (output valid, hit, status, evicted_valid, evicted_key, last,
                  input ready);
  modport sink   (input valid, hit, status, evicted_valid, evicted_key, last,
                  output ready);
endinterface

[src/lrp_ram.sv]
// ----------------------------------------------------------------------------
// lrp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[src/lru_residency_with_pinning_core.sv]
// ----------------------------------------------------------------------------
// lru_residency_with_pinning_core
// Recency-ordered residency table with pin bits; reports evicted keys.
// ----------------------------------------------------------------------------
// Operation: key lookup walks the key RAM; each eviction then takes a rank
//   scan, a key read and an emit step, plus a limit check step before every
//   eviction but the one that makes room for an insert.
// Requests: one request at a time; the next request is taken once the
//   last beat is staged.
// Reset: asynchronous, clears all entries, count and limit (16); key RAM
//   contents are not cleared, no clearing pass.
module lru_residency_with_pinning_core import lrp_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              max_resident_we_i,
  input  logic [MAXR_W-1:0] max_resident_i,
  lrp_in_if.sink            in_i,
  lrp_out_if.source         out_o
);

  localparam int IW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int SKW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int MW  = (CW > MAXR_W) ? CW : MAXR_W;

  state_e   state_q, state_d;
  op_e      op_q, op_d;
  ev_mode_e mode_q, mode_d;
  status_e  status_q, status_d;

  logic [SKW-1:0]    key_q, key_d;
  logic              hit_q, hit_d;
  logic              found_q, found_d;
  logic [IW-1:0]     fidx_q, fidx_d;
  logic [IW-1:0]     frank_q, frank_d;
  logic [IW:0]       scan_q, scan_d;
  logic              rv_q, rv_d;
  logic [IW-1:0]     ridx_q, ridx_d;
  logic [IW-1:0]     best_q, best_d;
  logic [IW-1:0]     brank_q, brank_d;
  logic              bvld_q, bvld_d;
  logic [NRES_W-1:0] nres_q, nres_d;
  logic [CW-1:0]     count_q, count_d;
  logic [MAXR_W-1:0] max_q;
  logic              pend_vld_q, pend_vld_d;
  logic [SKW-1:0]    pend_key_q, pend_key_d;

  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [CAPACITY-1:0] pin_q, pin_d;
  logic [IW-1:0]       rank_q [CAPACITY];
  logic [IW-1:0]       rank_d [CAPACITY];

  logic           ram_re, ram_we;
  logic [IW-1:0]  ram_raddr;
  logic [SKW-1:0] ram_rdata;

  logic [IW-1:0] sel_idx, slot;
  logic          sel_valid, sel_pin;
  logic [IW-1:0] sel_rank;
  logic          cand, better;

  logic          rm_en, pr_en, ins_en;
  logic [IW-1:0] act_idx, act_rank;

  logic           push, push_ev, push_last, can_push;
  logic [SKW-1:0] push_key;
  logic           in_acc;

  lrp_ram #(.WIDTH(SKW), .DEPTH(CAPACITY)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (key_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign can_push   = !out_o.valid || out_o.ready;

  assign sel_idx   = (state_q == S_FIND) ? ridx_q : scan_q[IW-1:0];
  assign sel_valid = valid_q[sel_idx];
  assign sel_pin   = pin_q[sel_idx];
  assign sel_rank  = rank_q[sel_idx];
  assign cand      = sel_valid && !sel_pin;
  assign better    = !bvld_q || ((mode_q == MODE_ALL) ? (sel_rank < brank_q)
                                                      : (sel_rank > brank_q));

  always_comb begin
    slot = '0;
    for (int j = CAPACITY - 1; j >= 0; j--) begin
      if (!valid_q[j]) slot = IW'(j);
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    mode_d     = mode_q;
    status_d   = status_q;
    key_d      = key_q;
    hit_d      = hit_q;
    found_d    = found_q;
    fidx_d     = fidx_q;
    frank_d    = frank_q;
    scan_d     = scan_q;
    rv_d       = rv_q;
    ridx_d     = ridx_q;
    best_d     = best_q;
    brank_d    = brank_q;
    bvld_d     = bvld_q;
    nres_d     = nres_q;
    count_d    = count_q;
    pend_vld_d = pend_vld_q;
    pend_key_d = pend_key_q;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = scan_q[IW-1:0];
    rm_en      = 1'b0;
    pr_en      = 1'b0;
    ins_en     = 1'b0;
    act_idx    = fidx_q;
    act_rank   = frank_q;
    push       = 1'b0;
    push_ev    = 1'b0;
    push_key   = '0;
    push_last  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d       = op_e'(in_i.operation);
          key_d      = in_i.key[SKW-1:0];
          hit_d      = 1'b0;
          status_d   = ST_OK;
          nres_d     = '0;
          pend_vld_d = 1'b0;
          found_d    = 1'b0;
          scan_d     = '0;
          rv_d       = 1'b0;
          case (in_i.operation) inside
            OP_TOUCH, OP_PIN, OP_UNPIN, OP_FORGET: state_d = S_FIND;
            OP_EVALL: begin
              mode_d  = MODE_ALL;
              state_d = S_CHECK;
            end
            OP_TRIM: begin
              mode_d  = MODE_LIMIT;
              state_d = S_CHECK;
            end
            default: state_d = S_FLUSH;
          endcase
        end
      end
      S_FIND: begin
        rv_d = 1'b0;
        if (scan_q < (IW+1)'(CAPACITY)) begin
          ram_re    = 1'b1;
          ram_raddr = scan_q[IW-1:0];
          scan_d    = scan_q + 1'b1;
          rv_d      = 1'b1;
          ridx_d    = scan_q[IW-1:0];
        end
        if (rv_q && sel_valid && (ram_rdata == key_q)) begin
          found_d = 1'b1;
          fidx_d  = ridx_q;
          frank_d = sel_rank;
          rv_d    = 1'b0;
          state_d = S_DECIDE;
        end else if (!rv_q && (scan_q == (IW+1)'(CAPACITY))) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_FLUSH;
        case (op_q)
          OP_TOUCH, OP_PIN: begin
            if (found_q) begin
              hit_d = 1'b1;
              pr_en = 1'b1;
            end else if (count_q == CW'(CAPACITY)) begin
              mode_d  = MODE_ROOM;
              scan_d  = '0;
              bvld_d  = 1'b0;
              state_d = S_SCAN;
            end else begin
              state_d = S_INSERT;
            end
          end
          OP_UNPIN, OP_FORGET: begin
            if (found_q) begin
              hit_d = 1'b1;
              if (op_q == OP_FORGET) begin
                rm_en   = 1'b1;
                count_d = count_q - 1'b1;
              end
            end else begin
              status_d = ST_ABSENT;
            end
          end
          default: state_d = S_FLUSH;
        endcase
      end
      S_SCAN: begin
        if (cand && better) begin
          best_d  = scan_q[IW-1:0];
          brank_d = sel_rank;
        end
        bvld_d = bvld_q || cand;
        if (scan_q == (IW+1)'(CAPACITY - 1)) begin
          if (!(bvld_q || cand)) begin
            if (mode_q == MODE_ROOM) status_d = ST_REJECT;
            state_d = S_FLUSH;
          end else begin
            state_d = S_RDKEY;
          end
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_RDKEY: begin
        ram_re    = 1'b1;
        ram_raddr = best_q;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (!pend_vld_q || can_push) begin
          push       = pend_vld_q;
          push_ev    = 1'b1;
          push_key   = pend_key_q;
          pend_key_d = ram_rdata;
          pend_vld_d = 1'b1;
          nres_d     = nres_q + 1'b1;
          rm_en      = 1'b1;
          act_idx    = best_q;
          act_rank   = brank_q;
          count_d    = count_q - 1'b1;
          state_d    = (mode_q == MODE_ROOM) ? S_INSERT : S_CHECK;
        end
      end
      S_INSERT: begin
        ram_we  = 1'b1;
        ins_en  = 1'b1;
        act_idx = slot;
        count_d = count_q + 1'b1;
        mode_d  = MODE_LIMIT;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if ((nres_q < NRES_W'(MAX_RESULTS)) &&
            ((mode_q == MODE_ALL) || (MW'(count_q) > MW'(max_q)))) begin
          scan_d  = '0;
          bvld_d  = 1'b0;
          state_d = S_SCAN;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (can_push) begin
          push       = 1'b1;
          push_ev    = pend_vld_q;
          push_key   = pend_vld_q ? pend_key_q : '0;
          push_last  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // entry table update: remove, promote, insert or unpin, at most one per cycle
  always_comb begin
    valid_d = valid_q;
    pin_d   = pin_q;
    rank_d  = rank_q;
    if (rm_en) begin
      for (int j = 0; j < CAPACITY; j++) begin
        if (valid_q[j] && (rank_q[j] > act_rank)) rank_d[j] = rank_q[j] - 1'b1;
      end
      valid_d[act_idx] = 1'b0;
      pin_d[act_idx]   = 1'b0;
      rank_d[act_idx]  = '0;
    end else if (pr_en) begin
      for (int j = 0; j < CAPACITY; j++) begin
        if (valid_q[j] && (rank_q[j] < act_rank)) rank_d[j] = rank_q[j] + 1'b1;
      end
      rank_d[act_idx] = '0;
      if (op_q == OP_PIN) pin_d[act_idx] = 1'b1;
    end else if (ins_en) begin
      for (int j = 0; j < CAPACITY; j++) begin
        if (valid_q[j]) rank_d[j] = rank_q[j] + 1'b1;
      end
      valid_d[act_idx] = 1'b1;
      pin_d[act_idx]   = (op_q == OP_PIN);
      rank_d[act_idx]  = '0;
    end else if ((state_q == S_DECIDE) && found_q && (op_q == OP_UNPIN)) begin
      pin_d[fidx_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_TOUCH;
      mode_q     <= MODE_LIMIT;
      status_q   <= ST_OK;
      hit_q      <= 1'b0;
      found_q    <= 1'b0;
      fidx_q     <= '0;
      frank_q    <= '0;
      scan_q     <= '0;
      rv_q       <= 1'b0;
      ridx_q     <= '0;
      best_q     <= '0;
      brank_q    <= '0;
      bvld_q     <= 1'b0;
      nres_q     <= '0;
      count_q    <= '0;
      max_q      <= MAXR_RESET;
      pend_vld_q <= 1'b0;
      valid_q    <= '0;
      pin_q      <= '0;
      for (int j = 0; j < CAPACITY; j++) rank_q[j] <= '0;
      out_o.valid <= 1'b0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      mode_q     <= mode_d;
      status_q   <= status_d;
      hit_q      <= hit_d;
      found_q    <= found_d;
      fidx_q     <= fidx_d;
      frank_q    <= frank_d;
      scan_q     <= scan_d;
      rv_q       <= rv_d;
      ridx_q     <= ridx_d;
      best_q     <= best_d;
      brank_q    <= brank_d;
      bvld_q     <= bvld_d;
      nres_q     <= nres_d;
      count_q    <= count_d;
      pend_vld_q <= pend_vld_d;
      valid_q    <= valid_d;
      pin_q      <= pin_d;
      rank_q     <= rank_d;
      if (max_resident_we_i) max_q <= max_resident_i;
      if (push) begin
        out_o.valid <= 1'b1;
      end else if (out_o.ready) begin
        out_o.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    pend_key_q <= pend_key_d;
    if (push) begin
      out_o.hit           <= hit_q;
      out_o.status        <= status_q;
      out_o.evicted_valid <= push_ev;
      out_o.evicted_key   <= KEY_W'(push_key);
      out_o.last          <= push_last;
    end
  end

endmodule

[src/lrp_checker.sv]
// ----------------------------------------------------------------------------
// lrp_checker
// Port-level checks of the residency table, bound to the top level.
// ----------------------------------------------------------------------------
module lrp_checker import lrp_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                hit,
  input logic [STATUS_W-1:0] status,
  input logic                evicted_valid,
  input logic                last
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(last))
    else $error("result beat dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  a_reject_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status == ST_REJECT || status == ST_ABSENT) |-> !evicted_valid && last)
    else $error("eviction reported on a rejected or absent request");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && hit |-> !evicted_valid && last)
    else $error("eviction reported on a hit");

endmodule

bind lru_residency_with_pinning_core lrp_checker u_lrp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .hit           (out_o.hit),
  .status        (out_o.status),
  .evicted_valid (out_o.evicted_valid),
  .last          (out_o.last)
);

[tb/tb_lru_residency_with_pinning_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_residency_with_pinning_core
// Drives touch/pin/unpin/forget/evict-all/trim requests and unused opcodes under
// random back-pressure and across several residency limits. Each result beat is
// checked field by field against a local model of the recency table.
// ----------------------------------------------------------------------------
module tb_lru_residency_with_pinning_core;
  import lrp_pkg::*;

  localparam int                NSLOT      = 16;
  localparam logic [OP_W-1:0]   OP_SPARE6  = 3'd6;
  localparam logic [OP_W-1:0]   OP_SPARE7  = 3'd7;
  localparam int                CYCLE_CAP  = 1000000;
  localparam int                LONG_HOLD  = 300;
  localparam int                SETTLE     = 40;

  typedef struct packed {
    logic                hit;
    logic [STATUS_W-1:0] status;
    logic                ev;
    logic [KEY_W-1:0]    ev_key;
    logic                last;
  } beat_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic             typed;
    logic             hit;
    status_e          status;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              max_resident_we_i = 1'b0;
  logic [MAXR_W-1:0] max_resident_i = '0;

  lrp_in_if  in_if ();
  lrp_out_if out_if ();

  lru_residency_with_pinning_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .max_resident_we_i (max_resident_we_i),
    .max_resident_i    (max_resident_i),
    .in_i              (in_if),
    .out_o             (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // table model
  logic [KEY_W-1:0]  slot_key   [NSLOT];
  bit                slot_valid [NSLOT];
  bit                slot_pin   [NSLOT];
  int                slot_age   [NSLOT];
  int                resident_n;
  logic [MAXR_W-1:0] limit_q;

  beat_t             due_q [$];
  int                errors = 0;
  int                cycles = 0;
  bit                quiet = 1'b0;
  bit                hold_req = 1'b0;
  logic [KEY_W-1:0]  pool [24];

  function automatic int find_slot(logic [KEY_W-1:0] k);
    for (int i = 0; i < NSLOT; i++)
      if (slot_valid[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int i);
    for (int j = 0; j < NSLOT; j++)
      if (slot_valid[j] && slot_age[j] > slot_age[i]) slot_age[j]--;
    slot_valid[i] = 0;
    slot_pin[i]   = 0;
    slot_age[i]   = 0;
    if (resident_n > 0) resident_n--;
  endfunction

  function automatic int oldest_free();
    int best;
    best = -1;
    for (int i = 0; i < NSLOT; i++)
      if (slot_valid[i] && !slot_pin[i] && (best < 0 || slot_age[i] > slot_age[best]))
        best = i;
    return best;
  endfunction

  function automatic beat_t evicted(logic [KEY_W-1:0] k);
    beat_t b;
    b = '0;
    b.ev = 1'b1;
    b.ev_key = k;
    return b;
  endfunction

  function automatic void trim_to_limit(ref beat_t res[$]);
    int v;
    while (res.size() < MAX_RESULTS && resident_n > limit_q) begin
      v = oldest_free();
      if (v < 0) break;
      res.push_back(evicted(slot_key[v]));
      drop_slot(v);
    end
  endfunction

  function automatic void apply_touch(logic [KEY_W-1:0] k, bit pin, ref beat_t res[$],
                                      ref logic hit, ref logic [STATUS_W-1:0] st);
    int i;
    int v;
    int free;
    i = find_slot(k);
    if (i >= 0) begin
      hit = 1'b1;
      for (int j = 0; j < NSLOT; j++)
        if (slot_valid[j] && slot_age[j] < slot_age[i]) slot_age[j]++;
      slot_age[i] = 0;
      if (pin) slot_pin[i] = 1;
      return;
    end
    if (resident_n >= NSLOT) begin
      v = oldest_free();
      if (v < 0) begin
        st = ST_REJECT;
        return;
      end
      res.push_back(evicted(slot_key[v]));
      drop_slot(v);
    end
    free = -1;
    for (int j = 0; j < NSLOT; j++)
      if (!slot_valid[j] && free < 0) free = j;
    for (int j = 0; j < NSLOT; j++)
      if (slot_valid[j]) slot_age[j]++;
    slot_key[free]   = k;
    slot_valid[free] = 1;
    slot_pin[free]   = pin;
    slot_age[free]   = 0;
    resident_n++;
    trim_to_limit(res);
  endfunction

  // works out the beats of one request and queues them
  function automatic void predict_beats(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                        row_t row);
    beat_t               res[$];
    logic                hit;
    logic [STATUS_W-1:0] st;
    int                  i;
    int                  best;
    hit = 1'b0;
    st  = ST_OK;
    case (op)
      OP_TOUCH: apply_touch(k, 0, res, hit, st);
      OP_PIN:   apply_touch(k, 1, res, hit, st);
      OP_UNPIN, OP_FORGET: begin
        i = find_slot(k);
        if (i < 0) begin
          st = ST_ABSENT;
        end else begin
          hit = 1'b1;
          if (op == OP_UNPIN) slot_pin[i] = 0;
          else drop_slot(i);
        end
      end
      OP_EVALL: begin
        while (res.size() < MAX_RESULTS) begin
          best = -1;
          for (int j = 0; j < NSLOT; j++)
            if (slot_valid[j] && !slot_pin[j] &&
                (best < 0 || slot_age[j] < slot_age[best])) best = j;
          if (best < 0) break;
          res.push_back(evicted(slot_key[best]));
          drop_slot(best);
        end
      end
      OP_TRIM: trim_to_limit(res);
      default: ;
    endcase
    if (res.size() == 0) res.push_back('0);
    if (row.typed) begin
      hit = row.hit;
      st  = row.status;
    end
    foreach (res[n]) begin
      res[n].hit    = hit;
      res[n].status = st;
      res[n].last   = (n == res.size() - 1);
      due_q.push_back(res[n]);
    end
  endfunction

  task automatic send(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, row_t row);
    bit took;
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.key       <= k;
    do begin
      @(negedge clk_i);
      took = in_if.ready;
      @(posedge clk_i);
    end while (!took);
    predict_beats(op, k, row);
  endtask

  task automatic gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [MAXR_W-1:0] v);
    max_resident_we_i <= 1'b1;
    max_resident_i    <= v;
    @(posedge clk_i);
    max_resident_we_i <= 1'b0;
    limit_q = v;
    @(posedge clk_i);
  endtask

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_TOUCH;
    if (r < 55) return OP_PIN;
    if (r < 68) return OP_UNPIN;
    if (r < 78) return OP_FORGET;
    if (r < 83) return OP_EVALL;
    if (r < 94) return OP_TRIM;
    return (r < 97) ? OP_SPARE6 : OP_SPARE7;
  endfunction

  // receiver
  initial begin
    out_if.ready = 1'b1;
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  always @(negedge clk_i) begin
    beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_q.size() == 0) begin
        $error("unexpected beat: evicted_key %h", out_if.evicted_key);
        errors++;
      end else begin
        want = due_q.pop_front();
        if (out_if.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_if.hit);
          errors++;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          errors++;
        end
        if (out_if.evicted_valid !== want.ev) begin
          $error("evicted_valid: expected %0d, got %0d", want.ev, out_if.evicted_valid);
          errors++;
        end
        if (out_if.evicted_key !== want.ev_key) begin
          $error("evicted_key: expected %h, got %h", want.ev_key, out_if.evicted_key);
          errors++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_if.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("lru_residency_with_pinning_core verification failed");
      $finish;
    end
  end

  row_t dir_rows[] = '{
    '{OP_UNPIN,  16'h0000, 1'b1, 1'b0, ST_ABSENT},
    '{OP_FORGET, 16'hFFFF, 1'b1, 1'b0, ST_ABSENT},
    '{OP_TOUCH,  16'h0000, 1'b1, 1'b0, ST_OK},
    '{OP_TOUCH,  16'hFFFF, 1'b1, 1'b0, ST_OK},
    '{OP_TOUCH,  16'h0000, 1'b1, 1'b1, ST_OK},
    '{OP_PIN,    16'h1234, 1'b1, 1'b0, ST_OK},
    '{OP_PIN,    16'h1234, 1'b1, 1'b1, ST_OK},
    '{OP_TOUCH,  16'hA5A5, 1'b0, 1'b0, ST_OK},
    '{OP_UNPIN,  16'h1234, 1'b1, 1'b1, ST_OK},
    '{OP_PIN,    16'h5A5A, 1'b0, 1'b0, ST_OK},
    '{OP_FORGET, 16'hFFFF, 1'b1, 1'b1, ST_OK},
    '{OP_FORGET, 16'hFFFF, 1'b1, 1'b0, ST_ABSENT},
    '{OP_EVALL,  16'h0000, 1'b1, 1'b0, ST_OK},
    '{OP_TRIM,   16'h0000, 1'b1, 1'b0, ST_OK},
    '{OP_SPARE6, 16'h0005, 1'b1, 1'b0, ST_OK},
    '{OP_SPARE7, 16'hFFFF, 1'b1, 1'b0, ST_OK},
    '{OP_UNPIN,  16'h5A5A, 1'b1, 1'b1, ST_OK},
    '{OP_TRIM,   16'h0000, 1'b0, 1'b0, ST_OK}
  };

  logic [MAXR_W-1:0] limits[] = '{5'd0, 5'd16, 5'd3, 5'd31, 5'd8, 5'd1, 5'd12, 5'd16};

  initial begin
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] k;
    in_if.valid     = 1'b0;
    in_if.operation = OP_TOUCH;
    in_if.key       = '0;
    foreach (slot_valid[i]) begin
      slot_key[i]   = '0;
      slot_valid[i] = 0;
      slot_pin[i]   = 0;
      slot_age[i]   = 0;
    end
    resident_n = 0;
    limit_q    = MAXR_RESET;
    foreach (pool[i]) pool[i] = KEY_W'($urandom_range(0, 16'hFFFF));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      send(dir_rows[r].op, dir_rows[r].key, dir_rows[r]);
      gap();
    end
    drain();

    foreach (limits[p]) begin
      set_limit(limits[p]);
      if (p == 2) hold_req = 1'b1;
      if (p == limits.size() - 1) quiet = 1'b1;
      for (int n = 0; n < 40; n++) begin
        op = pick_op();
        k  = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom_range(0, 16'hFFFF))
                                          : pool[$urandom_range(0, 23)];
        send(op, k, '0);
        gap();
      end
      drain();
    end

    if (errors == 0) begin
      $display("lru_residency_with_pinning_core verification clean");
    end else begin
      $display("lru_residency_with_pinning_core verification failed");
    end
    $finish;
  end

endmodule
